// ===== hw/rtl/wgr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weight GCD reducer package
// Shared widths, status codes and controller states of the weight reducer.
// ----------------------------------------------------------------------------
package wgr_pkg;

   localparam int WEIGHT_W   = 16;
   localparam int INDEX_W    = 6;
   localparam int STEP_W     = 12;
   localparam int STATUS_W   = 2;
   localparam int RSP_DATA_W = 56;
   localparam int DIV_CNT_W  = 4;

   localparam logic [STEP_W-1:0]    STEP_MAX = 12'hFFF;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EUCLID,
      S_MOD,
      S_FETCH,
      S_LOAD,
      S_QUOT,
      S_SEND
   } state_type;

endpackage : wgr_pkg
`default_nettype wire

// ===== hw/rtl/weight_gcd_reducer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Timing: a weight is taken in S_IDLE; each Euclid remainder step then runs a
//   set-up state (S_EUCLID) and the divider (S_MOD), and S_EUCLID ends the loop.
// Flow: one word at a time; each result word passes read, divider load, divider and
//   send states (no divider with a zero divisor), and send waits out stalls.
// Reset: synchronous, clears the run counters and the controller; the weight
//   memory is not cleared, as only entries written in the current set are read.
// ----------------------------------------------------------------------------
// Weight GCD reducer
// Collects a set of weights in a memory, folds each into a running GCD with a
// shared radix-2 divider, then streams every stored weight divided by the GCD.
// ----------------------------------------------------------------------------
module weight_gcd_reducer_unit #(
   parameter int MAX_WEIGHTS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [wgr_pkg::WEIGHT_W-1:0]       req_tdata,  // [15:0] weight
   input  wire logic                               req_tlast,  // last_weight
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [15:0] reduced_weight, [21:16] weight_index, [37:22] common_divisor,
   // [49:38] step_count, [51:50] status, [55:52] zero
   output      logic [wgr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output      logic                               rsp_tlast   // last_result
);

   localparam int ADDR_W  = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
   localparam int COUNT_W = $clog2(MAX_WEIGHTS + 1);
   localparam int W       = wgr_pkg::WEIGHT_W;

   wgr_pkg::state_type state_ff, state_in;

   logic [COUNT_W-1:0]              count_ff, count_in;
   logic [W-1:0]                    div_ff, div_in;
   logic [wgr_pkg::STEP_W-1:0]      steps_ff, steps_in;
   logic                            ovf_ff, ovf_in;
   logic                            last_ff, last_in;
   logic [ADDR_W-1:0]               k_ff, k_in;
   logic [wgr_pkg::DIV_CNT_W-1:0]   dv_cnt_ff, dv_cnt_in;

   logic [W-1:0]                    a_ff, a_in;
   logic [W-1:0]                    b_ff, b_in;
   logic [W-1:0]                    rem_ff, rem_in;
   logic [W-1:0]                    quo_ff, quo_in;
   logic [W-1:0]                    den_ff, den_in;
   logic [W-1:0]                    quot_ff, quot_in;

   logic [W-1:0]                    weight_store [MAX_WEIGHTS];
   logic [W-1:0]                    rd_ff;

   logic                            req_fire;
   logic                            store_full;
   logic                            mem_we;
   logic [W:0]                      dv_shift;
   logic [W:0]                      dv_diff;
   logic                            dv_fits;
   logic [W-1:0]                    rem_nx;
   logic [W-1:0]                    quo_nx;
   logic [wgr_pkg::STEP_W-1:0]      steps_inc;
   logic [wgr_pkg::STATUS_W-1:0]    status;
   logic                            is_last_rsp;

   // one restoring division step
   always_comb begin
      dv_shift = {rem_ff, quo_ff[W-1]};
      dv_diff  = dv_shift - {1'b0, den_ff};
      dv_fits  = ~dv_diff[W];
      rem_nx   = dv_fits ? dv_diff[W-1:0] : dv_shift[W-1:0];
      quo_nx   = {quo_ff[W-2:0], dv_fits};
   end

   assign steps_inc  = (steps_ff == wgr_pkg::STEP_MAX) ? steps_ff
                                                       : steps_ff + 1'b1;
   assign store_full = (count_ff == COUNT_W'(MAX_WEIGHTS));
   assign req_fire   = req_tvalid && req_tready;
   assign mem_we     = req_fire && !store_full;
   assign is_last_rsp = ((COUNT_W'(k_ff) + 1'b1) == count_ff);

   always_comb begin
      if (div_ff == '0) begin
         status = wgr_pkg::STATUS_ZERO;
      end else if (ovf_ff) begin
         status = wgr_pkg::STATUS_DROP;
      end else begin
         status = wgr_pkg::STATUS_OK;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      div_in     = div_ff;
      steps_in   = steps_ff;
      ovf_in     = ovf_ff;
      last_in    = last_ff;
      k_in       = k_ff;
      dv_cnt_in  = dv_cnt_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      den_in     = den_ff;
      quot_in    = quot_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      case (state_ff)
         wgr_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               last_in = req_tlast;
               k_in    = '0;
               if (store_full) begin
                  ovf_in = 1'b1;
                  if (req_tlast) begin
                     state_in = wgr_pkg::S_FETCH;
                  end
               end else begin
                  count_in = count_ff + 1'b1;
                  if (count_ff == '0) begin
                     div_in   = req_tdata;
                     steps_in = steps_inc;
                     if (req_tlast) begin
                        state_in = wgr_pkg::S_FETCH;
                     end
                  end else begin
                     a_in     = div_ff;
                     b_in     = req_tdata;
                     state_in = wgr_pkg::S_EUCLID;
                  end
               end
            end
         end
         wgr_pkg::S_EUCLID: begin
            if (a_ff == '0) begin
               div_in   = b_ff;
               state_in = last_ff ? wgr_pkg::S_FETCH : wgr_pkg::S_IDLE;
            end else begin
               steps_in  = steps_inc;
               rem_in    = '0;
               quo_in    = b_ff;
               den_in    = a_ff;
               dv_cnt_in = '0;
               state_in  = wgr_pkg::S_MOD;
            end
         end
         wgr_pkg::S_MOD: begin
            rem_in    = rem_nx;
            quo_in    = quo_nx;
            dv_cnt_in = dv_cnt_ff + 1'b1;
            if (dv_cnt_ff == wgr_pkg::DIV_LAST) begin
               // advance the pair: (a, b) <= (b mod a, a)
               a_in     = rem_nx;
               b_in     = a_ff;
               state_in = wgr_pkg::S_EUCLID;
            end
         end
         wgr_pkg::S_FETCH: begin
            // read address is k; data lands in rd_ff
            state_in = wgr_pkg::S_LOAD;
         end
         wgr_pkg::S_LOAD: begin
            if (div_ff == '0) begin
               quot_in  = '0;
               state_in = wgr_pkg::S_SEND;
            end else begin
               rem_in    = '0;
               quo_in    = rd_ff;
               den_in    = div_ff;
               dv_cnt_in = '0;
               state_in  = wgr_pkg::S_QUOT;
            end
         end
         wgr_pkg::S_QUOT: begin
            rem_in    = rem_nx;
            quo_in    = quo_nx;
            dv_cnt_in = dv_cnt_ff + 1'b1;
            if (dv_cnt_ff == wgr_pkg::DIV_LAST) begin
               quot_in  = quo_nx;
               state_in = wgr_pkg::S_SEND;
            end
         end
         wgr_pkg::S_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (is_last_rsp) begin
                  // drop the run and wait for the next set
                  count_in = '0;
                  div_in   = '0;
                  steps_in = '0;
                  ovf_in   = 1'b0;
                  last_in  = 1'b0;
                  k_in     = '0;
                  state_in = wgr_pkg::S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = wgr_pkg::S_FETCH;
               end
            end
         end
         default: begin
            state_in = wgr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= wgr_pkg::S_IDLE;
         count_ff  <= '0;
         div_ff    <= '0;
         steps_ff  <= '0;
         ovf_ff    <= 1'b0;
         last_ff   <= 1'b0;
         k_ff      <= '0;
         dv_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         div_ff    <= div_in;
         steps_ff  <= steps_in;
         ovf_ff    <= ovf_in;
         last_ff   <= last_in;
         k_ff      <= k_in;
         dv_cnt_ff <= dv_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_store[count_ff[ADDR_W-1:0]] <= req_tdata;
      end
      rd_ff <= weight_store[k_ff];
   end

   assign rsp_tdata = {4'b0000, status, steps_ff, div_ff,
                       wgr_pkg::INDEX_W'(k_ff), quot_ff};
   assign rsp_tlast = is_last_rsp;

`ifndef SYNTHESIS
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result sides active together");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_WEIGHTS))
      else $error("stored count beyond capacity");

   a_send_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (count_ff != '0))
      else $error("result offered from an empty set");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (div_ff == '0)) |-> (quot_ff == '0))
      else $error("nonzero result with zero divisor");

   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (count_ff == '0) && req_tready)
      else $error("run not cleared after final result");
`endif

endmodule : weight_gcd_reducer_unit
`default_nettype wire

// ===== dv/tb_weight_gcd_reducer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weight GCD reducer testbench
// Streams weight sets into the reducer and predicts every reduced word:
// divisor, step count and status included. Directed sets cover the extremes,
// a long Euclid chain and a full store; random sets of mixed shape follow.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_weight_gcd_reducer_unit;

   localparam int SET_CAPACITY = 16;
   localparam int RANDOM_ITEMS = 130;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [wgr_pkg::WEIGHT_W-1:0] reduced;
      logic [wgr_pkg::INDEX_W-1:0]  index;
      logic [wgr_pkg::WEIGHT_W-1:0] divisor;
      logic [wgr_pkg::STEP_W-1:0]   steps;
      logic [wgr_pkg::STATUS_W-1:0] status;
      logic                         is_last;
   } reduced_word_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [wgr_pkg::WEIGHT_W-1:0]   req_tdata;   // [15:0] weight
   logic                           req_tlast;   // last_weight
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   // [15:0] reduced_weight, [21:16] weight_index, [37:22] common_divisor,
   // [49:38] step_count, [51:50] status, [55:52] zero
   logic [wgr_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;   // last_result

   // running copy of the set being gathered
   logic [wgr_pkg::WEIGHT_W-1:0] set_weights [SET_CAPACITY];
   int unsigned                  set_count;
   int unsigned                  set_divisor;
   int unsigned                  set_steps;
   bit                           set_dropped;

   reduced_word_type pending_reduced [$];
   int               fail_count;
   int               items_sent;
   int               idle_cycles;
   bit               calm;

   weight_gcd_reducer_unit #(
      .MAX_WEIGHTS (SET_CAPACITY)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void bump_steps();
      if (set_steps < wgr_pkg::STEP_MAX) set_steps++;
   endfunction

   // Fold one accepted weight into the set and, on the last one, queue the words.
   function automatic void fold_weight(input logic [wgr_pkg::WEIGHT_W-1:0] w,
                                       input logic is_last);
      int unsigned                  a;
      int unsigned                  b;
      int unsigned                  c;
      reduced_word_type             word;
      logic [wgr_pkg::STATUS_W-1:0] status;
      if (set_count < SET_CAPACITY) begin
         if (set_count == 0) begin
            set_divisor = w;
            bump_steps();
         end else begin
            a = set_divisor;
            b = w;
            while (a != 0) begin
               bump_steps();
               c = a;
               a = b % a;
               b = c;
            end
            set_divisor = b & 16'hFFFF;
         end
         set_weights[set_count] = w;
         set_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (!is_last) return;
      if (set_divisor == 0) status = wgr_pkg::STATUS_ZERO;
      else if (set_dropped) status = wgr_pkg::STATUS_DROP;
      else status = wgr_pkg::STATUS_OK;
      for (int k = 0; k < set_count; k++) begin
         word.reduced = (set_divisor == 0) ? '0
                        : wgr_pkg::WEIGHT_W'(set_weights[k] / set_divisor);
         word.index   = wgr_pkg::INDEX_W'(k);
         word.divisor = wgr_pkg::WEIGHT_W'(set_divisor);
         word.steps   = wgr_pkg::STEP_W'(set_steps);
         word.status  = status;
         word.is_last = (k + 1 == set_count);
         pending_reduced = {pending_reduced, word};
      end
      set_count   = 0;
      set_divisor = 0;
      set_steps   = 0;
      set_dropped = 1'b0;
   endfunction

   task automatic send_weight(input logic [wgr_pkg::WEIGHT_W-1:0] w, input logic is_last);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      fold_weight(w, is_last);
      items_sent++;
   endtask

   task automatic test_extremes();
      send_weight(16'hFFFF, 1'b1);
      send_weight(16'h0000, 1'b0);
      send_weight(16'h0000, 1'b1);
      // zero first, then a real weight: divisor is taken over without steps
      send_weight(16'h0000, 1'b0);
      send_weight(16'd12, 1'b1);
      send_weight(16'hFFFF, 1'b0);
      send_weight(16'h0001, 1'b1);
   endtask

   task automatic test_long_euclid();
      // consecutive Fibonacci numbers give the longest remainder chain
      send_weight(16'd46368, 1'b0);
      send_weight(16'd28657, 1'b1);
   endtask

   task automatic test_store_full();
      // one weight beyond capacity, flagged last, is dropped
      for (int k = 0; k <= SET_CAPACITY; k++)
         send_weight(16'(3 * $urandom_range(0, 21845)), k == SET_CAPACITY);
   endtask

   task automatic test_random_sets();
      int                           len;
      int                           mode;
      int unsigned                  base;
      logic [wgr_pkg::WEIGHT_W-1:0] w;
      while (items_sent < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         len  = $urandom_range(0, 9);
         if (len < 7) len = $urandom_range(1, 8);
         else if (len < 9) len = $urandom_range(9, SET_CAPACITY);
         else len = $urandom_range(SET_CAPACITY + 1, SET_CAPACITY + 4);
         base = $urandom_range(1, 4096);
         calm = ($urandom_range(0, 4) == 0);
         for (int k = 0; k < len; k++) begin
            if (mode < 3) begin
               w = wgr_pkg::WEIGHT_W'($urandom_range(0, 16'hFFFF));
            end else if (mode < 7) begin
               w = wgr_pkg::WEIGHT_W'(base * $urandom_range(0, 65535 / base));
            end else if (mode < 8) begin
               w = '0;
            end else if (mode < 9) begin
               w = ($urandom_range(0, 2) == 0) ? '0
                   : wgr_pkg::WEIGHT_W'(base * $urandom_range(1, 3));
            end else begin
               w = 16'(1) << $urandom_range(0, 15);
            end
            send_weight(w, k == len - 1);
         end
      end
      calm = 1'b0;
   endtask

   // result side: random back-pressure
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_words
      reduced_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reduced.size() == 0) begin
            $error("result word %h with nothing expected", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_reduced.pop_front();
            check_field("reduced_weight", want.reduced, rsp_tdata[15:0]);
            check_field("weight_index", want.index, rsp_tdata[21:16]);
            check_field("common_divisor", want.divisor, rsp_tdata[37:22]);
            check_field("step_count", want.steps, rsp_tdata[49:38]);
            check_field("status", want.status, rsp_tdata[51:50]);
            check_field("pad", 0, rsp_tdata[55:52]);
            check_field("last_result", want.is_last, rsp_tlast);
         end
      end
   end

   // hang guard: no word moving on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      fail_count  = 0;
      items_sent  = 0;
      calm        = 1'b0;
      set_count   = 0;
      set_divisor = 0;
      set_steps   = 0;
      set_dropped = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_long_euclid();
      test_store_full();
      test_random_sets();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_reduced.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
